@@ rtl/tpts_pkg.sv @@
// types and constants shared by the timer and task scheduler
// no dependencies
`timescale 1ns / 1ps

package tpts_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int NUM_TASKS_DEF  = 8;
   localparam logic [15:0] TICK_RESET = 16'd10;

   typedef enum logic [3:0] {
      OP_TICK      = 4'd0,
      OP_REG_TIMER = 4'd1,
      OP_GET_TIMER = 4'd2,
      OP_RELOAD    = 4'd3,
      OP_START_TMR = 4'd4,
      OP_STOP_TMR  = 4'd5,
      OP_REG_TASK  = 4'd6,
      OP_STOP_TASK = 4'd7,
      OP_START_TSK = 4'd8,
      OP_SET_PER   = 4'd9
   } opcode_type;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_EXPIRE = 2'd1;
   localparam logic [1:0] KIND_DUE    = 2'd2;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [4:0]  slot;
      logic [31:0] amount;
      logic        has_handler;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [4:0]  event_slot;
      logic [31:0] reply_value;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CMD,
      ST_TIMERS,
      ST_TASKS,
      ST_DONE
   } state_type;

   // command handed to one cell
   typedef struct packed {
      logic        tick;
      logic        sel;
      logic        do_reg;
      logic        do_load;
      logic        do_start;
      logic        do_stop;
      logic [31:0] amount;
      logic        handler;
   } cell_cmd_type;

endpackage

@@ rtl/timer_and_periodic_task_scheduler.sv @@
// timer and periodic task scheduler: command decode, sequencer, cell rows
// a command: remainder check on the amount, then decode and reply
// a tick: cell update, then timer events, task events, last marker; no new item while busy
// at most one result per cycle on the strobe; the receiver cannot stall
// reset: synchronous, clears all tables, tasks enabled, tick length 10
// depends on tpts_pkg, tpts_mod, tpts_timer_cell, tpts_task_cell
`timescale 1ns / 1ps

module timer_and_periodic_task_scheduler #(
   parameter int NUM_TIMERS = tpts_pkg::NUM_TIMERS_DEF,
   parameter int NUM_TASKS  = tpts_pkg::NUM_TASKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tpts_pkg::req_type req_data,
   output logic              rsp_valid,
   output tpts_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import tpts_pkg::*;

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [15:0] tick_ff;
   logic [4:0]  tused_ff, tused_in, kused_ff, kused_in;
   logic [4:0]  idx_ff, idx_in;
   logic        amt_ok_ff, amt_ok_in;
   logic        mod_start, mod_done, mod_zero;
   cell_cmd_type tcmd [NUM_TIMERS];
   cell_cmd_type kcmd [NUM_TASKS];
   logic [2:0]  tevt [NUM_TIMERS+1];
   logic [31:0] trem [NUM_TIMERS];
   logic        kdue [NUM_TASKS+1];
   logic        tshift, kshift, tick_go, cmd_go;
   logic        tmr_ok, tsk_ok;
   logic [4:0]  tidx, kidx;
   rsp_type     rsp_in;
   logic        rsp_v_in;
   logic [31:0] r;

   assign busy = (state_ff != ST_IDLE);

   tpts_mod u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(req_data.amount),
      .divisor(tick_ff), .done(mod_done), .zero_rem(mod_zero)
   );

   assign tmr_ok = (req_ff.slot != 5'd0) && (req_ff.slot <= tused_ff)
                   && (32'(req_ff.slot) <= 32'(NUM_TIMERS));
   assign tsk_ok = (req_ff.slot != 5'd0) && (32'(req_ff.slot) <= 32'(NUM_TASKS));
   assign tidx   = req_ff.slot - 5'd1;
   assign kidx   = req_ff.slot - 5'd1;
   assign tick_go = (state_ff == ST_MOD) && (req_ff.opcode == OP_TICK);
   assign cmd_go  = (state_ff == ST_CMD);
   assign tshift  = (state_ff == ST_TIMERS);
   assign kshift  = (state_ff == ST_TASKS);
   assign mod_start = (state_ff == ST_IDLE) && start;

   assign tevt[0] = 3'b000;
   assign kdue[0] = 1'b0;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
      always_comb begin
         tcmd[g]          = '0;
         tcmd[g].tick     = tick_go;
         tcmd[g].amount   = req_ff.amount;
         tcmd[g].handler  = req_ff.has_handler;
         tcmd[g].sel      = cmd_go;
         if (req_ff.opcode == OP_REG_TIMER) begin
            tcmd[g].do_reg = amt_ok_ff && (32'(tused_ff) == g)
                             && (32'(tused_ff) < 32'(NUM_TIMERS));
         end else if (tmr_ok && 32'(tidx) == g) begin
            tcmd[g].do_load  = (req_ff.opcode == OP_RELOAD);
            tcmd[g].do_start = (req_ff.opcode == OP_START_TMR);
            tcmd[g].do_stop  = (req_ff.opcode == OP_STOP_TMR);
         end
      end
      // cell g hands its flag toward cell 0, toward the output at the low end
      tpts_timer_cell u_cell (
         .clock(clock), .reset(reset), .cmd(tcmd[g]), .shift(tshift),
         .evt_in(tevt[g+2 > NUM_TIMERS ? 0 : g+2]),
         .evt_out(tevt[g+1]), .remaining(trem[g])
      );
   end

   for (genvar g = 0; g < NUM_TASKS; g++) begin : g_tsk
      always_comb begin
         kcmd[g]         = '0;
         kcmd[g].tick    = tick_go;
         kcmd[g].amount  = req_ff.amount;
         kcmd[g].handler = req_ff.has_handler;
         kcmd[g].sel     = cmd_go;
         if (req_ff.opcode == OP_REG_TASK) begin
            kcmd[g].do_reg = amt_ok_ff && req_ff.has_handler && (32'(kused_ff) == g)
                             && (32'(kused_ff) < 32'(NUM_TASKS));
         end else if (tsk_ok && 32'(kidx) == g) begin
            kcmd[g].do_load  = (req_ff.opcode == OP_SET_PER) && amt_ok_ff;
            kcmd[g].do_start = (req_ff.opcode == OP_START_TSK);
            kcmd[g].do_stop  = (req_ff.opcode == OP_STOP_TASK);
         end
      end
      tpts_task_cell u_cell (
         .clock(clock), .reset(reset), .cmd(kcmd[g]), .tick_length(tick_ff),
         .shift(kshift), .due_in(kdue[g+2 > NUM_TASKS ? 0 : g+2]),
         .due_out(kdue[g+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_MOD;
         ST_MOD: begin
            if (req_ff.opcode == OP_TICK) state_in = ST_TIMERS;
            else if (mod_done) state_in = ST_CMD;
         end
         ST_CMD:    state_in = ST_IDLE;
         ST_TIMERS: if (32'(idx_ff) == NUM_TIMERS - 1) state_in = ST_TASKS;
         ST_TASKS:  if (32'(idx_ff) == NUM_TASKS - 1) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in    = '0;
      amt_ok_in = amt_ok_ff;
      tused_in  = tused_ff;
      kused_in  = kused_ff;
      rsp_v_in  = 1'b0;
      rsp_in    = '0;
      r         = '0;
      if (state_ff == ST_MOD && mod_done)
         amt_ok_in = mod_zero && (req_ff.amount != 32'd0);
      if (state_ff == ST_TIMERS && 32'(idx_ff) != NUM_TIMERS - 1) idx_in = idx_ff + 5'd1;
      if (state_ff == ST_TASKS && 32'(idx_ff) != NUM_TASKS - 1) idx_in = idx_ff + 5'd1;
      case (state_ff)
         ST_TIMERS: begin
            rsp_v_in           = tevt[1][1];
            rsp_in.event_kind  = KIND_EXPIRE;
            rsp_in.event_slot  = idx_ff + 5'd1;
         end
         ST_TASKS: begin
            rsp_v_in           = kdue[1];
            rsp_in.event_kind  = KIND_DUE;
            rsp_in.event_slot  = idx_ff + 5'd1;
         end
         ST_DONE: begin
            rsp_v_in    = 1'b1;
            rsp_in.last = 1'b1;
         end
         ST_CMD: begin
            case (req_ff.opcode)
               OP_REG_TIMER: if (amt_ok_ff && 32'(tused_ff) < NUM_TIMERS) begin
                  tused_in = tused_ff + 5'd1;
                  r        = {27'd0, tused_in};
               end
               OP_GET_TIMER: if (tmr_ok) begin
                  for (int i = 0; i < NUM_TIMERS; i++)
                     if (32'(tidx) == i) r = trem[i];
               end
               OP_RELOAD, OP_START_TMR, OP_STOP_TMR: r = {31'd0, tmr_ok};
               OP_REG_TASK: if (amt_ok_ff && req_ff.has_handler
                                && 32'(kused_ff) < NUM_TASKS) begin
                  kused_in = kused_ff + 5'd1;
                  r        = {27'd0, kused_in};
               end
               OP_STOP_TASK, OP_START_TSK: r = {31'd0, tsk_ok};
               OP_SET_PER: r = {31'd0, tsk_ok && amt_ok_ff};
               default: r = '0;
            endcase
            rsp_v_in           = 1'b1;
            rsp_in.reply_value = r;
            rsp_in.last        = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tick_ff   <= TICK_RESET;
         tused_ff  <= '0;
         kused_ff  <= '0;
         idx_ff    <= '0;
         amt_ok_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_we && csr_wdata != 16'd0) tick_ff <= csr_wdata;
         tused_ff  <= tused_in;
         kused_ff  <= kused_in;
         idx_ff    <= idx_in;
         amt_ok_ff <= amt_ok_in;
         rsp_valid <= rsp_v_in;
      end
      rsp_data <= rsp_in;
      if (start && !busy) req_ff <= req_data;
   end

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid || !rsp_data.last || $past(state_ff) == ST_DONE
         || $past(state_ff) == ST_CMD) else $error("double last");
   a_tick_nz: assert property (@(posedge clock) disable iff (reset)
      tick_ff != 16'd0) else $error("tick length zero");
   a_used: assert property (@(posedge clock) disable iff (reset)
      32'(tused_ff) <= NUM_TIMERS && 32'(kused_ff) <= NUM_TASKS) else $error("used overflow");
`endif

endmodule

@@ rtl/tpts_mod.sv @@
// serial remainder unit, one quotient bit per cycle
// depends on tpts_pkg
`timescale 1ns / 1ps

module tpts_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic        zero_rem
);
   import tpts_pkg::*;

   logic [16:0] rem_ff, rem_in;
   logic [31:0] sh_ff, sh_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [16:0] trial;

   always_comb begin
      trial  = {rem_ff[15:0], sh_ff[31]};
      rem_in = rem_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         rem_in = '0;
         sh_in  = dividend;
         cnt_in = 6'd32;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         sh_in  = {sh_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign done     = run_ff && (cnt_ff == 6'd1);
   assign zero_rem = (rem_in == 17'd0);

endmodule

@@ rtl/tpts_timer_cell.sv @@
// one timer cell; counts live in the cell, chained by a shift line
// depends on tpts_pkg
`timescale 1ns / 1ps

module tpts_timer_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tpts_pkg::cell_cmd_type cmd,
   input  logic                  shift,
   input  logic [2:0]            evt_in,
   output logic [2:0]            evt_out,
   output logic [31:0]           remaining
);
   import tpts_pkg::*;

   // evt bits: unused, fire, unused
   logic [31:0] reload_ff, reload_in, rem_ff, rem_in;
   logic        run_ff, run_in, hnd_ff, hnd_in;
   logic        fire_ff, fire_in;
   logic [31:0] dec;

   always_comb begin
      reload_in = reload_ff;
      rem_in    = rem_ff;
      run_in    = run_ff;
      hnd_in    = hnd_ff;
      fire_in   = shift ? evt_in[1] : fire_ff;
      dec       = (rem_ff != 32'd0) ? rem_ff - 32'd1 : rem_ff;
      if (cmd.tick) begin
         fire_in = 1'b0;
         if (run_ff) begin
            rem_in = dec;
            if (dec == 32'd0) begin
               run_in  = 1'b0;
               fire_in = hnd_ff;
            end
         end
      end else if (cmd.sel) begin
         if (cmd.do_reg) begin
            reload_in = cmd.amount;
            hnd_in    = cmd.handler;
         end
         if (cmd.do_load) rem_in = cmd.amount;
         if (cmd.do_start) begin
            run_in = 1'b1;
            rem_in = reload_ff;
         end
         if (cmd.do_stop) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= '0;
         rem_ff    <= '0;
         run_ff    <= 1'b0;
         hnd_ff    <= 1'b0;
         fire_ff   <= 1'b0;
      end else begin
         reload_ff <= reload_in;
         rem_ff    <= rem_in;
         run_ff    <= run_in;
         hnd_ff    <= hnd_in;
         fire_ff   <= fire_in;
      end
   end

   assign evt_out   = {1'b0, fire_ff, 1'b0};
   assign remaining = rem_ff;

endmodule

@@ rtl/tpts_task_cell.sv @@
// one periodic task cell; due flags chained by a shift line
// depends on tpts_pkg
`timescale 1ns / 1ps

module tpts_task_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tpts_pkg::cell_cmd_type cmd,
   input  logic [15:0]           tick_length,
   input  logic                  shift,
   input  logic                  due_in,
   output logic                  due_out
);
   import tpts_pkg::*;

   logic [31:0] per_ff, per_in, ela_ff, ela_in;
   logic        en_ff, en_in, pres_ff, pres_in, due_ff, due_in_c;
   logic [32:0] sum;
   logic [31:0] e;

   always_comb begin
      per_in   = per_ff;
      ela_in   = ela_ff;
      en_in    = en_ff;
      pres_in  = pres_ff;
      due_in_c = shift ? due_in : due_ff;
      sum      = {1'b0, ela_ff} + {17'd0, tick_length};
      e        = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (cmd.tick) begin
         ela_in   = e;
         due_in_c = 1'b0;
         if (e >= per_ff) begin
            ela_in   = '0;
            due_in_c = en_ff && pres_ff;
         end
      end else if (cmd.sel) begin
         if (cmd.do_reg) begin
            per_in  = cmd.amount;
            pres_in = 1'b1;
         end
         if (cmd.do_load) per_in = cmd.amount;
         if (cmd.do_start) en_in = 1'b1;
         if (cmd.do_stop) en_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         per_ff  <= '0;
         ela_ff  <= '0;
         en_ff   <= 1'b1;
         pres_ff <= 1'b0;
         due_ff  <= 1'b0;
      end else begin
         per_ff  <= per_in;
         ela_ff  <= ela_in;
         en_ff   <= en_in;
         pres_ff <= pres_in;
         due_ff  <= due_in_c;
      end
   end

   assign due_out = due_ff;

endmodule
